@@ hdl/sao_pkg.sv @@
// Shared types, constants, the divider step and quotient saturation of the straight-alpha over blend.
package sao_pkg;

    // Alpha scale constants: full alpha and its square.
    localparam logic [7:0]  ALPHA_FULL = 8'd255;
    localparam logic [15:0] ALPHA_SQ   = 16'd65025;

    // Blend divider geometry: three color lanes plus the alpha lane.
    localparam int LANES      = 4;
    localparam int LANE_ALPHA = 3;
    localparam int QUO_W      = 9;
    localparam int DEN_W      = 25;
    localparam int REM_W      = DEN_W + QUO_W - 1;
    localparam int DIV_STEPS  = QUO_W;

    // Denominator of the alpha lane: twice the square of full alpha.
    localparam logic [DEN_W-1:0] ALPHA_DEN = DEN_W'(2 * 65025);

    // One RGBA8 pixel.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_rgba;

    // Source and destination pixel of one item.
    typedef struct packed {
        t_rgba src;
        t_rgba dst;
    } t_pix_pair;

    // State of one lane of the restoring divider.
    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic [QUO_W-1:0] quo;
    } t_div_lane;

    // One restoring division step: try to take the denominator shifted by sh.
    function automatic t_div_lane div_step(input t_div_lane l, input int unsigned sh);
        logic [REM_W-1:0] d_sh;
        t_div_lane        r;
        d_sh = {{(REM_W - DEN_W){1'b0}}, l.den} << sh;
        r    = l;
        if (l.rem >= d_sh) begin
            r.rem = l.rem - d_sh;
            r.quo = {l.quo[QUO_W-2:0], 1'b1};
        end else begin
            r.quo = {l.quo[QUO_W-2:0], 1'b0};
        end
        return r;
    endfunction

    // Saturate a divider quotient to eight bits.
    function automatic logic [7:0] sat8(input logic [QUO_W-1:0] q);
        logic [7:0] r;
        r = (q > QUO_W'(ALPHA_FULL)) ? ALPHA_FULL : q[7:0];
        return r;
    endfunction

endpackage

@@ hdl/sao_if.sv @@
// Valid/ready channel interfaces of the blend: pixel input, pixel output, opacity write.

interface sao_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] src_red;
    logic [7:0] src_green;
    logic [7:0] src_blue;
    logic [7:0] src_alpha;
    logic [7:0] dst_red;
    logic [7:0] dst_green;
    logic [7:0] dst_blue;
    logic [7:0] dst_alpha;

    modport source (
        output valid, src_red, src_green, src_blue, src_alpha,
               dst_red, dst_green, dst_blue, dst_alpha,
        input  ready
    );
    modport sink (
        input  valid, src_red, src_green, src_blue, src_alpha,
               dst_red, dst_green, dst_blue, dst_alpha,
        output ready
    );
endinterface

interface sao_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;

    modport source (
        output valid, out_red, out_green, out_blue, out_alpha,
        input  ready
    );
    modport sink (
        input  valid, out_red, out_green, out_blue, out_alpha,
        output ready
    );
endinterface

interface sao_cfg_if;
    logic       valid;
    logic       ready;
    logic [7:0] layer_opacity;

    modport source (
        output valid, layer_opacity,
        input  ready
    );
    modport sink (
        input  valid, layer_opacity,
        output ready
    );
endinterface

@@ hdl/straight_alpha_over_blend.sv @@
// Straight-alpha source-over-destination blend of one RGBA8 pixel pair per transfer.
//
// Channels: i_in carries a source and a destination pixel, o_out carries the blended
// pixel, i_cfg writes the layer opacity that scales the source alpha. All use valid
// and ready; a transfer happens at a rising edge where both are high. i_cfg is always
// ready and must only be written while no pixel is in flight.
// Pipeline: a result passes through 14 register stages: one for the opacity product, two
// for the blend products, one for numerator and denominator set-up, nine for the restoring
// divider (one quotient bit per stage) and the output register. Throughput is one pixel per
// cycle while o_out is not stalled.
// Stalls: every stage holds a valid bit and loads whenever it is empty or the stage
// after it moves, so bubbles are squeezed out and i_in stays ready while o_out is
// stalled until all 14 stages hold pixels. Nothing is dropped or repeated.
// Reset (i_rst_n low, synchronous): all stages are emptied and the opacity returns
// to 255 (fully opaque).
module straight_alpha_over_blend (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sao_cfg_if.sink     i_cfg,
    sao_in_if.sink      i_in,
    sao_out_if.source   o_out
);

    localparam int NSTEP = sao_pkg::DIV_STEPS;
    localparam int NLANE = sao_pkg::LANES;

    // Opacity register.
    logic [7:0] r_opacity;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_opacity <= sao_pkg::ALPHA_FULL;
        end else if (i_cfg.valid) begin
            r_opacity <= i_cfg.layer_opacity;
        end
    end

    // Stage valid bits and load enables.
    logic             r_v0, r_v1, r_v2, r_v3, r_vo;
    logic [NSTEP-1:0] r_vd;
    logic             en0, en1, en2, en3, en_o;
    logic [NSTEP-1:0] en_d;

    always_comb begin
        en_o          = !r_vo || o_out.ready;
        en_d[NSTEP-1] = !r_vd[NSTEP-1] || en_o;
        for (int k = NSTEP - 2; k >= 0; k--) begin
            en_d[k] = !r_vd[k] || en_d[k+1];
        end
        en3 = !r_v3 || en_d[0];
        en2 = !r_v2 || en3;
        en1 = !r_v1 || en2;
        en0 = !r_v0 || en1;
    end

    assign i_in.ready = en0;

    // Stage 0: capture the pixel pair and form the effective source alpha.
    sao_pkg::t_pix_pair n_pix0;
    sao_pkg::t_pix_pair r_pix0;
    logic [15:0]        r_s0;

    assign n_pix0 = '{src: '{red: i_in.src_red, green: i_in.src_green,
                             blue: i_in.src_blue, alpha: i_in.src_alpha},
                      dst: '{red: i_in.dst_red, green: i_in.dst_green,
                             blue: i_in.dst_blue, alpha: i_in.dst_alpha}};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (en0) begin
            r_v0 <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en0) begin
            r_pix0 <= n_pix0;
            r_s0   <= 16'(i_in.src_alpha) * 16'(r_opacity);
        end
    end

    // Stage 1: source weight 255*S and destination weight d*(65025-S).
    sao_pkg::t_pix_pair r_pix1;
    logic               r_zero1, r_full1;
    logic [23:0]        r_t1, r_u1;
    logic [15:0]        ns0;

    assign ns0 = sao_pkg::ALPHA_SQ - r_s0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en1) begin
            r_v1 <= r_v0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_pix1  <= r_pix0;
            r_zero1 <= (r_s0 == 16'd0);
            r_full1 <= (r_s0 == sao_pkg::ALPHA_SQ);
            r_t1    <= {r_s0, 8'd0} - {8'd0, r_s0};
            r_u1    <= 24'(r_pix0.dst.alpha) * 24'(ns0);
        end
    end

    // Stage 2: result alpha sum and the per-channel products.
    sao_pkg::t_pix_pair r_pix2;
    logic               r_zero2, r_full2;
    logic [23:0]        r_a2;
    logic [31:0]        r_p1_2 [3];
    logic [31:0]        r_p2_2 [3];
    logic [7:0]         sc1 [3];
    logic [7:0]         dc1 [3];

    assign sc1[0] = r_pix1.src.red;
    assign sc1[1] = r_pix1.src.green;
    assign sc1[2] = r_pix1.src.blue;
    assign dc1[0] = r_pix1.dst.red;
    assign dc1[1] = r_pix1.dst.green;
    assign dc1[2] = r_pix1.dst.blue;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_pix2  <= r_pix1;
            r_zero2 <= r_zero1;
            r_full2 <= r_full1;
            r_a2    <= r_t1 + r_u1;
            for (int c = 0; c < 3; c++) begin
                r_p1_2[c] <= 32'(sc1[c]) * 32'(r_t1);
                r_p2_2[c] <= 32'(dc1[c]) * 32'(r_u1);
            end
        end
    end

    // Stage 3: rounded numerators, denominators and the pass-through pixel.
    sao_pkg::t_div_lane n_lane3 [NLANE];
    sao_pkg::t_div_lane r_lane3 [NLANE];
    logic               n_byp3, r_byp3;
    sao_pkg::t_rgba     n_bpix3, r_bpix3;
    logic [32:0]        sum2 [3];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            sum2[c]        = {1'b0, r_p1_2[c]} + {1'b0, r_p2_2[c]};
            n_lane3[c].rem = {sum2[c][31:0], 1'b0} + {9'd0, r_a2};
            n_lane3[c].den = {r_a2, 1'b0};
            n_lane3[c].quo = '0;
        end
        n_lane3[sao_pkg::LANE_ALPHA].rem = {8'd0, r_a2, 1'b0} + 33'(sao_pkg::ALPHA_SQ);
        n_lane3[sao_pkg::LANE_ALPHA].den = sao_pkg::ALPHA_DEN;
        n_lane3[sao_pkg::LANE_ALPHA].quo = '0;
        n_byp3 = r_zero2 || r_full2 || (r_a2 == 24'd0);
        if (r_full2 && !r_zero2) begin
            n_bpix3 = '{red: r_pix2.src.red, green: r_pix2.src.green,
                        blue: r_pix2.src.blue, alpha: sao_pkg::ALPHA_FULL};
        end else begin
            n_bpix3 = r_pix2.dst;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (en3) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_lane3 <= n_lane3;
            r_byp3  <= n_byp3;
            r_bpix3 <= n_bpix3;
        end
    end

    // Divider stages: one quotient bit per stage, most significant first.
    sao_pkg::t_div_lane r_lane_d [NSTEP][NLANE];
    logic [NSTEP-1:0]   r_byp_d;
    sao_pkg::t_rgba     r_bpix_d [NSTEP];

    for (genvar k = 0; k < NSTEP; k++) begin : g_div
        sao_pkg::t_div_lane prev_lane [NLANE];
        logic               prev_v;
        logic               prev_byp;
        sao_pkg::t_rgba     prev_bpix;

        if (k == 0) begin : g_first
            assign prev_lane = r_lane3;
            assign prev_v    = r_v3;
            assign prev_byp  = r_byp3;
            assign prev_bpix = r_bpix3;
        end else begin : g_next
            assign prev_lane = r_lane_d[k-1];
            assign prev_v    = r_vd[k-1];
            assign prev_byp  = r_byp_d[k-1];
            assign prev_bpix = r_bpix_d[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vd[k] <= 1'b0;
            end else if (en_d[k]) begin
                r_vd[k] <= prev_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en_d[k]) begin
                for (int l = 0; l < NLANE; l++) begin
                    r_lane_d[k][l] <= sao_pkg::div_step(prev_lane[l], NSTEP - 1 - k);
                end
                r_byp_d[k]  <= prev_byp;
                r_bpix_d[k] <= prev_bpix;
            end
        end
    end

    // Output register: pass-through pixel or saturated quotients.
    sao_pkg::t_rgba r_out;
    sao_pkg::t_rgba n_out;

    always_comb begin
        if (r_byp_d[NSTEP-1]) begin
            n_out = r_bpix_d[NSTEP-1];
        end else begin
            n_out.red   = sao_pkg::sat8(r_lane_d[NSTEP-1][0].quo);
            n_out.green = sao_pkg::sat8(r_lane_d[NSTEP-1][1].quo);
            n_out.blue  = sao_pkg::sat8(r_lane_d[NSTEP-1][2].quo);
            n_out.alpha = sao_pkg::sat8(r_lane_d[NSTEP-1][sao_pkg::LANE_ALPHA].quo);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (en_o) begin
            r_vo <= r_vd[NSTEP-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_o) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid     = r_vo;
    assign o_out.out_red   = r_out.red;
    assign o_out.out_green = r_out.green;
    assign o_out.out_blue  = r_out.blue;
    assign o_out.out_alpha = r_out.alpha;

endmodule
